>>> design/rle565_pkg.sv
// ----------------------------------------------------------------------------
// rle565_pkg
// shared types and constants for the rgb565 run-length encoder
// ----------------------------------------------------------------------------
package rle565_pkg;

   localparam int unsigned RUN_MAX_VAL = 255;
   localparam logic [7:0]  RUN_MAX     = 8'(RUN_MAX_VAL);

   localparam int unsigned Q_DEPTH   = 4;
   localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [7:0] chan_first;
      logic [7:0] chan_second;
      logic [7:0] chan_third;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] run_length;
      logic [7:0] color_high;
      logic [7:0] color_low;
      logic       closes_frame;
      logic       last_result;
   } rsp_type;

   function automatic logic [15:0] pack565(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
      pack565 = {a[7:3], b[7:2], c[7:3]};
   endfunction

endpackage

>>> design/rgb565_run_length_encoder_core.sv
// ----------------------------------------------------------------------------
// rgb565_run_length_encoder_core
// packs pixels to rgb565 and emits run-length records of count and color
// ----------------------------------------------------------------------------
// One pixel item is accepted per clock while req_ready is high. Each accepted
// item is resolved in the same cycle against the held run color and count,
// and the zero, one or two records it closes are written into a four-entry
// result queue, whose registered count drives rsp_valid. req_ready is high while
// the queue has at least two free entries, so with the result side taking one
// record per cycle the block sustains one pixel per cycle; a pixel that both
// changes color and ends a frame adds two records and can slow the input to
// the output rate of one record per cycle. No clearing pass follows reset.
module rgb565_run_length_encoder_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rle565_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rle565_pkg::rsp_type rsp_data
);

   logic [15:0] held_color_ff, held_color_in;
   logic [7:0]  run_count_ff, run_count_in;

   rle565_pkg::rsp_type             queue_ff [rle565_pkg::Q_DEPTH];
   logic [rle565_pkg::Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rle565_pkg::Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rle565_pkg::Q_CNT_W-1:0]  count_ff, count_in;

   logic [15:0] pix_color;
   logic [15:0] run_color;
   logic        accept;
   logic        pop;
   logic        brk;
   logic        push_break;
   logic        push_end;
   logic [rle565_pkg::Q_CNT_W-1:0] push_cnt;
   logic [7:0]  next_count;
   logic [rle565_pkg::Q_PTR_W-1:0] end_ptr;
   rle565_pkg::rsp_type rec_break;
   rle565_pkg::rsp_type rec_end;

   assign req_ready = (count_ff <= rle565_pkg::Q_CNT_W'(rle565_pkg::Q_DEPTH - 2));
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & rsp_ready;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      pix_color  = rle565_pkg::pack565(req_data.chan_first, req_data.chan_second,
                                       req_data.chan_third);
      run_color  = (run_count_ff == '0) ? pix_color : held_color_ff;
      brk        = (run_color != pix_color) || (run_count_ff == rle565_pkg::RUN_MAX);
      next_count = brk ? 8'd1 : run_count_ff + 8'd1;
      push_break = accept & brk;
      push_end   = accept & req_data.frame_end;
      push_cnt   = rle565_pkg::Q_CNT_W'(push_break) + rle565_pkg::Q_CNT_W'(push_end);
      end_ptr    = push_break ? wr_ptr_ff + 1'b1 : wr_ptr_ff;

      rec_break.run_length   = run_count_ff;
      rec_break.color_high   = run_color[15:8];
      rec_break.color_low    = run_color[7:0];
      rec_break.closes_frame = 1'b0;
      rec_break.last_result  = ~req_data.frame_end;

      rec_end.run_length     = next_count;
      rec_end.color_high     = pix_color[15:8];
      rec_end.color_low      = pix_color[7:0];
      rec_end.closes_frame   = 1'b1;
      rec_end.last_result    = 1'b1;

      held_color_in = accept ? pix_color : held_color_ff;
      run_count_in  = run_count_ff;
      if (accept) begin
         run_count_in = req_data.frame_end ? 8'd0 : next_count;
      end

      wr_ptr_in = wr_ptr_ff + rle565_pkg::Q_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + rle565_pkg::Q_PTR_W'(pop);
      count_in  = count_ff + push_cnt - rle565_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_color_ff <= '0;
         run_count_ff  <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         held_color_ff <= held_color_in;
         run_count_ff  <= run_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_break) begin
         queue_ff[wr_ptr_ff] <= rec_break;
      end
      if (push_end) begin
         queue_ff[end_ptr] <= rec_end;
      end
   end

endmodule

>>> design/rle565_checker.sv
// ----------------------------------------------------------------------------
// rle565_checker
// port-level checks on the run-length encoder result stream
// ----------------------------------------------------------------------------
module rle565_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input rle565_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rle565_pkg::rsp_type rsp_data
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // no empty run is ever reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.run_length != 8'd0)
      else $error("result item with zero run length");

   // the frame-closing record is always the last of its pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.closes_frame |-> rsp_data.last_result)
      else $error("frame close not marked last");

   // a frame-end pixel produces a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.frame_end |=> rsp_valid)
      else $error("frame end produced no result item");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rgb565_run_length_encoder_core rle565_checker u_rle565_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
